/* hw/rtl/cqc_pkg.sv */
// ----------------------------------------------------------------------------
// Convex quadrilateral counter package
// Sizes, derived widths, the sweep state type and the cross unit's status.
// ----------------------------------------------------------------------------
`default_nettype none

package cqc_pkg;

  localparam int MAX_POINTS = 2048;
  localparam int COORD_BITS = 21;

  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;

  // binomial widths: C(n,2) < 2^(2w-1), C(n,3) < 2^(3w-2), C(n,4) < 2^(4w-4)
  localparam int C2_W  = 2 * CNT_W - 1;
  localparam int C3_W  = 3 * CNT_W - 2;
  localparam int C4_W  = 4 * CNT_W - 4;
  localparam int SUM_W = 3 * CNT_W;

  localparam int PCOUNT_W = 12;
  localparam int INSIDE_W = 40;
  localparam int TRI_W    = 31;

  localparam logic [63:0] PCOUNT_MAX = (64'd1 << PCOUNT_W) - 64'd1;
  localparam logic [63:0] INSIDE_MAX = (64'd1 << INSIDE_W) - 64'd1;
  localparam logic [63:0] TRI_MAX    = (64'd1 << TRI_W) - 64'd1;

  typedef struct packed {
    logic busy;
    logic hit;
  } cross_res_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PREP,
    ST_CRD,
    ST_CLAT,
    ST_JRD,
    ST_JLAT,
    ST_PSWEEP,
    ST_DRAIN,
    ST_BIN,
    ST_BADD,
    ST_CEND,
    ST_DONE
  } cqc_state_t;

endpackage

`default_nettype wire

/* hw/rtl/cqc_if.sv */
// ----------------------------------------------------------------------------
// Convex quadrilateral counter channels
// Point input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cqc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cqc_pkg::COORD_BITS-1:0] point_x;
  logic signed [cqc_pkg::COORD_BITS-1:0] point_y;
  logic                                  last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface cqc_out_if;
  logic                            valid;
  logic                            ready;
  logic [cqc_pkg::PCOUNT_W-1:0]    point_count;
  logic [cqc_pkg::INSIDE_W-1:0]    inside_total;
  logic [cqc_pkg::INSIDE_W-1:0]    convex_count;
  logic [cqc_pkg::TRI_W-1:0]       triangle_count;
  logic                            too_few_points;
  logic                            overflowed;

  modport source (output valid, point_count, inside_total, convex_count, triangle_count,
                  too_few_points, overflowed, input ready);
  modport sink   (input valid, point_count, inside_total, convex_count, triangle_count,
                  too_few_points, overflowed, output ready);
endinterface

`default_nettype wire

/* hw/rtl/convex_quadrilateral_counter_top.sv */
// ----------------------------------------------------------------------------
// Convex quadrilateral counter
// Stores a point set, then counts point-in-triangle containments by sweep.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one point per transfer; a transfer with last_point set
//   closes the set and starts the sweep. Points load at one per cycle while
//   in_chan.ready is high; points beyond MAX_POINTS are dropped and flagged.
//   out_chan carries one result per set: point count, containment total,
//   convex count C(n,4) - total, C(n,3) and flags.
//   The sweep walks every centre c, every other point j and every point p
//   through one memory read port, which sets the pace: one p a cycle.
//   in_chan.ready is low during the sweep.
//   Reset clears the point count, drop flag, accumulator and result valid;
//   the point memory is not cleared, only entries written are ever read.
//   The result sits in an output register, so the next set loads while the
//   result waits; a second result waits in the sweep until out_chan.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module convex_quadrilateral_counter_top (
  input  logic      clk,
  input  logic      rst_n,
  cqc_in_if.sink    in_chan,
  cqc_out_if.source out_chan
);
  import cqc_pkg::*;

  // point memory
  logic signed [COORD_BITS-1:0] x_mem [MAX_POINTS];
  logic signed [COORD_BITS-1:0] y_mem [MAX_POINTS];
  logic signed [COORD_BITS-1:0] rd_x_r, rd_y_r;
  logic [ADDR_W-1:0]            rd_addr;
  logic                         rd_en, wr_en, in_fire, issue;

  cqc_state_t state_r, state_nxt;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt, c_r, c_nxt, j_r, j_nxt, p_r, p_nxt;
  logic [CNT_W-1:0]  lcnt_r, lcnt_nxt, last_idx;
  logic              drop_r, drop_nxt, rd_vld_r;
  logic [C2_W-1:0]   c2_r, c2_nxt;
  logic [C3_W-1:0]   c3_r, c3_nxt, cn13_r, cn13_nxt, held;
  logic [C4_W-1:0]   c4_r, c4_nxt;
  logic [INSIDE_W-1:0] acc_r, acc_nxt;
  logic [INSIDE_W:0] acc_sum;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [2*CNT_W-1:0] lprod_r, lprod_nxt;
  logic signed [COORD_BITS-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [DIFF_W-1:0]     djx_r, djx_nxt, djy_r, djy_nxt, jdx, jdy;
  logic [63:0]       cvx_diff;
  cross_res_t        xres;

  logic                out_valid_r, out_valid_nxt;
  logic [PCOUNT_W-1:0] o_pcount_r, o_pcount_nxt;
  logic [INSIDE_W-1:0] o_inside_r, o_inside_nxt, o_convex_r, o_convex_nxt;
  logic [TRI_W-1:0]    o_tri_r, o_tri_nxt;
  logic                o_few_r, o_few_nxt, o_ovf_r, o_ovf_nxt;

  assign in_chan.ready = (state_r == ST_LOAD);
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign wr_en    = in_fire && (cnt_r < CNT_W'(MAX_POINTS));
  assign last_idx = cnt_r - CNT_W'(1);

  assign jdx = DIFF_W'(rd_x_r) - DIFF_W'(cx_r);
  assign jdy = DIFF_W'(rd_y_r) - DIFF_W'(cy_r);

  // containments at this centre: C(n-1,3) less the triangles not holding it
  assign held     = (SUM_W'(cn13_r) > sum_r) ? C3_W'(SUM_W'(cn13_r) - sum_r) : '0;
  assign acc_sum  = (INSIDE_W+1)'(acc_r) + (INSIDE_W+1)'(held);
  assign cvx_diff = (64'(c4_r) > 64'(acc_r)) ? 64'(c4_r) - 64'(acc_r) : 64'd0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_mem[cnt_r[ADDR_W-1:0]] <= in_chan.point_x;
      y_mem[cnt_r[ADDR_W-1:0]] <= in_chan.point_y;
    end
    if (rd_en) begin
      rd_x_r <= x_mem[rd_addr];
      rd_y_r <= y_mem[rd_addr];
    end
  end

  cqc_cross_unit u_cross (
    .clk   (clk),
    .rst_n (rst_n),
    .in_vld(rd_vld_r),
    .px    (rd_x_r),
    .py    (rd_y_r),
    .cx    (cx_r),
    .cy    (cy_r),
    .djx   (djx_r),
    .djy   (djy_r),
    .res   (xres)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    c2_nxt        = c2_r;
    c3_nxt        = c3_r;
    c4_nxt        = c4_r;
    cn13_nxt      = cn13_r;
    acc_nxt       = acc_r;
    c_nxt         = c_r;
    j_nxt         = j_r;
    p_nxt         = p_r;
    lcnt_nxt      = lcnt_r;
    lprod_nxt     = lprod_r;
    sum_nxt       = sum_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    djx_nxt       = djx_r;
    djy_nxt       = djy_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    issue         = 1'b0;
    out_valid_nxt = out_valid_r;
    o_pcount_nxt  = o_pcount_r;
    o_inside_nxt  = o_inside_r;
    o_convex_nxt  = o_convex_r;
    o_tri_nxt     = o_tri_r;
    o_few_nxt     = o_few_r;
    o_ovf_nxt     = o_ovf_r;

    // drop the result once the receiver takes it
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    // count points strictly left of the current line
    if (xres.hit) begin
      lcnt_nxt = lcnt_r + CNT_W'(1);
    end

    unique case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          if (wr_en) begin
            // advance C(n,k) to C(n+1,k) by Pascal's rule
            cnt_nxt = cnt_r + CNT_W'(1);
            c2_nxt  = c2_r + C2_W'(cnt_r);
            c3_nxt  = c3_r + C3_W'(c2_r);
            c4_nxt  = c4_r + C4_W'(c3_r);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_chan.last_point) begin
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        // C(n-1,3) = C(n,3) - C(n,2) + n - 1
        cn13_nxt  = c3_r - C3_W'(c2_r) + C3_W'(cnt_r) - C3_W'(1);
        c_nxt     = '0;
        state_nxt = ST_CRD;
      end
      ST_CRD: begin
        rd_en     = 1'b1;
        rd_addr   = c_r[ADDR_W-1:0];
        state_nxt = ST_CLAT;
      end
      ST_CLAT: begin
        cx_nxt    = rd_x_r;
        cy_nxt    = rd_y_r;
        j_nxt     = '0;
        sum_nxt   = '0;
        state_nxt = ST_JRD;
      end
      ST_JRD: begin
        rd_en     = 1'b1;
        rd_addr   = j_r[ADDR_W-1:0];
        state_nxt = ST_JLAT;
      end
      ST_JLAT: begin
        djx_nxt = jdx;
        djy_nxt = jdy;
        if (jdx == '0 && jdy == '0) begin
          // the centre itself or a copy of it: no line
          if (j_r == last_idx) begin
            state_nxt = ST_CEND;
          end else begin
            j_nxt     = j_r + CNT_W'(1);
            state_nxt = ST_JRD;
          end
        end else begin
          p_nxt     = '0;
          lcnt_nxt  = '0;
          state_nxt = ST_PSWEEP;
        end
      end
      ST_PSWEEP: begin
        rd_en   = 1'b1;
        rd_addr = p_r[ADDR_W-1:0];
        issue   = 1'b1;
        p_nxt   = p_r + CNT_W'(1);
        if (p_r == last_idx) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_r && !xres.busy) begin
          state_nxt = ST_BIN;
        end
      end
      ST_BIN: begin
        lprod_nxt = (2*CNT_W)'(lcnt_r) * (2*CNT_W)'(lcnt_r - CNT_W'(1));
        state_nxt = ST_BADD;
      end
      ST_BADD: begin
        sum_nxt = sum_r + SUM_W'(lprod_r >> 1);
        if (j_r == last_idx) begin
          state_nxt = ST_CEND;
        end else begin
          j_nxt     = j_r + CNT_W'(1);
          state_nxt = ST_JRD;
        end
      end
      ST_CEND: begin
        acc_nxt = acc_sum[INSIDE_W] ? '1 : acc_sum[INSIDE_W-1:0];
        if (c_r == last_idx) begin
          state_nxt = ST_DONE;
        end else begin
          c_nxt     = c_r + CNT_W'(1);
          state_nxt = ST_CRD;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          o_pcount_nxt  = (64'(cnt_r) > PCOUNT_MAX) ? '1 : PCOUNT_W'(cnt_r);
          o_inside_nxt  = acc_r;
          o_convex_nxt  = (cvx_diff > INSIDE_MAX) ? '1 : INSIDE_W'(cvx_diff);
          o_tri_nxt     = (64'(c3_r) > TRI_MAX) ? '1 : TRI_W'(c3_r);
          o_few_nxt     = (cnt_r < CNT_W'(3));
          o_ovf_nxt     = drop_r;
          cnt_nxt       = '0;
          drop_nxt      = 1'b0;
          acc_nxt       = '0;
          c2_nxt        = '0;
          c3_nxt        = '0;
          c4_nxt        = '0;
          state_nxt     = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      acc_r       <= '0;
      c2_r        <= '0;
      c3_r        <= '0;
      c4_r        <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      acc_r       <= acc_nxt;
      c2_r        <= c2_nxt;
      c3_r        <= c3_nxt;
      c4_r        <= c4_nxt;
      rd_vld_r    <= issue;
      out_valid_r <= out_valid_nxt;
    end
    cn13_r     <= cn13_nxt;
    c_r        <= c_nxt;
    j_r        <= j_nxt;
    p_r        <= p_nxt;
    lcnt_r     <= lcnt_nxt;
    lprod_r    <= lprod_nxt;
    sum_r      <= sum_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    djx_r      <= djx_nxt;
    djy_r      <= djy_nxt;
    o_pcount_r <= o_pcount_nxt;
    o_inside_r <= o_inside_nxt;
    o_convex_r <= o_convex_nxt;
    o_tri_r    <= o_tri_nxt;
    o_few_r    <= o_few_nxt;
    o_ovf_r    <= o_ovf_nxt;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.point_count    = o_pcount_r;
  assign out_chan.inside_total   = o_inside_r;
  assign out_chan.convex_count   = o_convex_r;
  assign out_chan.triangle_count = o_tri_r;
  assign out_chan.too_few_points = o_few_r;
  assign out_chan.overflowed     = o_ovf_r;

endmodule

`default_nettype wire

/* hw/rtl/cqc_cross_unit.sv */
// ----------------------------------------------------------------------------
// Cross-product sign unit
// Three-stage pipe: offset from centre, two products, strict-left compare.
// ----------------------------------------------------------------------------
`default_nettype none

module cqc_cross_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_vld,
  input  logic signed [cqc_pkg::COORD_BITS-1:0] px,
  input  logic signed [cqc_pkg::COORD_BITS-1:0] py,
  input  logic signed [cqc_pkg::COORD_BITS-1:0] cx,
  input  logic signed [cqc_pkg::COORD_BITS-1:0] cy,
  input  logic signed [cqc_pkg::DIFF_W-1:0]     djx,
  input  logic signed [cqc_pkg::DIFF_W-1:0]     djy,
  output cqc_pkg::cross_res_t                   res
);
  import cqc_pkg::*;

  logic                     va_r, vb_r, hit_r;
  logic signed [DIFF_W-1:0] dpx_r, dpy_r, dpx_nxt, dpy_nxt;
  logic signed [PROD_W-1:0] pa_r, pb_r, pa_nxt, pb_nxt;
  logic                     hit_nxt;

  assign dpx_nxt = DIFF_W'(px) - DIFF_W'(cx);
  assign dpy_nxt = DIFF_W'(py) - DIFF_W'(cy);
  assign pa_nxt  = PROD_W'(djx) * PROD_W'(dpy_r);
  assign pb_nxt  = PROD_W'(djy) * PROD_W'(dpx_r);
  // strictly left of centre->j when the cross product is positive
  assign hit_nxt = vb_r && (pa_r > pb_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      va_r  <= in_vld;
      vb_r  <= va_r;
      hit_r <= hit_nxt;
    end
    dpx_r <= dpx_nxt;
    dpy_r <= dpy_nxt;
    pa_r  <= pa_nxt;
    pb_r  <= pb_nxt;
  end

  assign res.busy = va_r | vb_r | hit_r;
  assign res.hit  = hit_r;

endmodule

`default_nettype wire

/* hw/rtl/cqc_checker.sv */
// ----------------------------------------------------------------------------
// Convex quadrilateral counter checker
// Port-level properties of the counter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cqc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_last,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [cqc_pkg::PCOUNT_W-1:0] out_point_count,
  input logic [cqc_pkg::INSIDE_W-1:0] out_inside_total,
  input logic [cqc_pkg::INSIDE_W-1:0] out_convex_count,
  input logic [cqc_pkg::TRI_W-1:0]    out_triangle_count,
  input logic                         out_too_few_points
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken while sweep runs");

  a_small_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_too_few_points |->
      out_triangle_count == '0 && out_inside_total == '0 &&
      out_convex_count == '0 && out_point_count < cqc_pkg::PCOUNT_W'(3))
    else $error("small set gives non-zero counts");

endmodule

bind convex_quadrilateral_counter_top cqc_checker u_cqc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .in_last           (in_chan.last_point),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_point_count   (out_chan.point_count),
  .out_inside_total  (out_chan.inside_total),
  .out_convex_count  (out_chan.convex_count),
  .out_triangle_count(out_chan.triangle_count),
  .out_too_few_points(out_chan.too_few_points)
);

`default_nettype wire
